// File: hdl/sqmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqmf_pkg: shared types for the shortest-queue multi-FIFO unit
// Transaction payloads, item kinds and the controller/datapath link structs.
// ----------------------------------------------------------------------------
package sqmf_pkg;

  localparam logic KIND_ARRIVE = 1'b0;
  localparam logic KIND_SERVE  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] exec_time;
    logic [2:0]  queue_index;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        item_valid;
    logic [2:0]  queue_number;
    logic [15:0] item_time;
  } out_item_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;     // latch the incoming transaction, restart the scan
    logic scan_step;   // compare one queue count against the running minimum
    logic arr_commit;  // store the arrival (if room) and post its result
    logic srv_read;    // pop the named queue (if possible), read its head
    logic out_load;    // post the serve result
  } sqmf_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic scan_last;   // the scan is at the last active queue
  } sqmf_stat_t;

endpackage

// File: hdl/sqmf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqmf_ctrl: sequencer for the shortest-queue multi-FIFO unit
// Steps an arrival through the count scan and commit, a serve through read
// and result posting.
// ----------------------------------------------------------------------------
module sqmf_ctrl
  import sqmf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       in_kind,
  input  sqmf_stat_t stat,
  output sqmf_cmd_t  cmd,
  output logic       busy
);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_SCAN    = 5'b00010,
    ST_COMMIT  = 5'b00100,
    ST_SRV_RD  = 5'b01000,
    ST_SRV_OUT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = (in_kind == KIND_SERVE) ? ST_SRV_RD : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.arr_commit = 1'b1;
        state_nxt      = ST_IDLE;
      end
      ST_SRV_RD: begin
        cmd.srv_read = 1'b1;
        state_nxt    = ST_SRV_OUT;
      end
      ST_SRV_OUT: begin
        cmd.out_load = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// File: hdl/sqmf_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqmf_dpath: datapath of the shortest-queue multi-FIFO unit
// Per-queue counts and heads, entry memory, minimum scan and result register.
// ----------------------------------------------------------------------------
module sqmf_dpath
  import sqmf_pkg::*;
#(
  parameter int MAX_QUEUES  = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_item,
  input  logic       cfg_we,
  input  logic [3:0] cfg_data,
  input  sqmf_cmd_t  cmd,
  output sqmf_stat_t stat,
  output logic       out_valid,
  output out_item_t  out_item
);

  localparam int QIW     = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
  localparam int HW      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW      = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRIES = MAX_QUEUES * QUEUE_DEPTH;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [CW:0]   DEPTH_S = (CW + 1)'(QUEUE_DEPTH);
  localparam logic [AW-1:0] DEPTH_A = AW'(QUEUE_DEPTH);
  localparam logic [7:0]    MAXQ_C  = 8'(MAX_QUEUES);

  logic [3:0]    cfg_r;
  in_item_t      item_r;
  logic [QIW-1:0] scan_idx_r, best_r;
  logic [CW-1:0] best_cnt_r;
  logic [CW-1:0] cnt_r  [MAX_QUEUES];
  logic [HW-1:0] head_r [MAX_QUEUES];
  logic [15:0]   mem    [ENTRIES];
  logic [15:0]   rdata_r;
  logic          hit_r;
  logic          out_valid_r;
  out_item_t     out_r;

  logic [7:0]     act;
  logic [QIW-1:0] last_idx, srv_q, rd_q;
  logic [CW-1:0]  rd_cnt;
  logic [HW-1:0]  rd_head, head_inc;
  logic [CW:0]    pos_sum;
  logic [HW-1:0]  tail_pos;
  logic [AW-1:0]  base_addr, wr_addr, rd_addr;
  logic           srv_hit, arr_room, mem_we, mem_re;

  // Active queue count: zero acts as one, saturate at the bank size
  always_comb begin
    act = (cfg_r == 4'd0) ? 8'd1 : {4'd0, cfg_r};
    if (act > MAXQ_C) begin
      act = MAXQ_C;
    end
  end
  assign last_idx       = QIW'(act - 8'd1);
  assign stat.scan_last = (scan_idx_r == last_idx);

  // One shared read port on the count and head registers
  assign srv_q   = QIW'(item_r.queue_index);
  assign rd_q    = cmd.srv_read ? srv_q : (cmd.scan_step ? scan_idx_r : best_r);
  assign rd_cnt  = cnt_r[rd_q];
  assign rd_head = head_r[rd_q];

  assign srv_hit  = ({5'd0, item_r.queue_index} < act) && (rd_cnt != '0);
  assign arr_room = (best_cnt_r < DEPTH_C);

  // Tail position wraps inside the queue's region
  always_comb begin
    pos_sum = (CW + 1)'(rd_head) + (CW + 1)'(best_cnt_r);
    if (pos_sum >= DEPTH_S) begin
      pos_sum = pos_sum - DEPTH_S;
    end
    tail_pos = HW'(pos_sum);
    head_inc = (rd_head == HW'(QUEUE_DEPTH - 1)) ? '0 : rd_head + HW'(1);
  end

  assign base_addr = AW'(rd_q) * DEPTH_A;
  assign wr_addr   = base_addr + AW'(tail_pos);
  assign rd_addr   = base_addr + AW'(rd_head);
  assign mem_we    = cmd.arr_commit && arr_room;
  assign mem_re    = cmd.srv_read && srv_hit;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= item_r.exec_time;
    end
    if (mem_re) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Control state: configuration, counts, heads, result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= 4'd1;
      out_valid_r <= 1'b0;
      for (int q = 0; q < MAX_QUEUES; q++) begin
        cnt_r[q]  <= '0;
        head_r[q] <= '0;
      end
    end else begin
      out_valid_r <= cmd.arr_commit || cmd.out_load;
      if (cfg_we) begin
        cfg_r <= cfg_data;
      end
      if (mem_we) begin
        cnt_r[best_r] <= best_cnt_r + CW'(1);
      end
      if (mem_re) begin
        cnt_r[srv_q]  <= rd_cnt - CW'(1);
        head_r[srv_q] <= head_inc;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r     <= in_item;
      scan_idx_r <= '0;
    end
    if (cmd.scan_step) begin
      if ((scan_idx_r == '0) || (rd_cnt < best_cnt_r)) begin
        best_r     <= scan_idx_r;
        best_cnt_r <= rd_cnt;
      end
      scan_idx_r <= scan_idx_r + QIW'(1);
    end
    if (cmd.srv_read) begin
      hit_r <= srv_hit;
    end
    if (cmd.arr_commit) begin
      out_r.accepted     <= arr_room;
      out_r.item_valid   <= 1'b0;
      out_r.queue_number <= 3'(best_r);
      out_r.item_time    <= '0;
    end
    if (cmd.out_load) begin
      out_r.accepted     <= 1'b0;
      out_r.item_valid   <= hit_r;
      out_r.queue_number <= item_r.queue_index;
      out_r.item_time    <= hit_r ? rdata_r : 16'd0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// File: hdl/shortest_queue_multi_fifo_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shortest_queue_multi_fifo_unit: join-shortest-queue FIFO bank
// Dispatches arrivals to the least-filled active queue; serves named queues.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_item and raise start; the transaction is taken at the
//   edge where start is high and busy is low. kind ARRIVE pushes exec_time
//   onto the active queue with the fewest entries (lowest index on a tie);
//   kind SERVE pops the queue named by queue_index.
//   Output: one result per transaction, shown on out_item for exactly one
//   cycle with out_valid high. The receiver cannot stall; sample it then.
//   Config: write queues_in_use on cfg_data with cfg_valid/cfg_ready while
//   busy is low; 0 acts as 1 and values above MAX_QUEUES saturate.
// Sequence:
//   Arrival: the minimum search walks the active counts one queue a cycle,
//   then a commit state stores the entry and registers the result; a new
//   transaction can be taken in the same cycle that out_valid is high.
//   Serve: a read state fetches the head entry, then a post state registers the result.
// Reset:
//   rst_n (synchronous, low) empties every queue and sets queues_in_use to
//   1. The entry memory keeps its contents; only written entries are read.
// ----------------------------------------------------------------------------
module shortest_queue_multi_fifo_unit
  import sqmf_pkg::*;
#(
  parameter int MAX_QUEUES  = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_item,
  output logic       out_valid,
  output out_item_t  out_item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_data
);

  sqmf_cmd_t  cmd;
  sqmf_stat_t stat;

  // Hold off configuration while a transaction is in flight
  assign cfg_ready = !busy;

  sqmf_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_item.kind),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  sqmf_dpath #(
    .MAX_QUEUES  (MAX_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// File: hdl/sqmf_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqmf_chk: port-level checks for the shortest-queue multi-FIFO unit
// Watches transaction acceptance, result strobes and result field coherence.
// ----------------------------------------------------------------------------
module sqmf_chk
  import sqmf_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_item
);

  // An accepted transaction occupies the unit
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // A result is a single-cycle strobe
  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // The unit finishes exactly when its result appears
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // Arrival and serve flags never mix; no item means zero time
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!(out_item.accepted && out_item.item_valid) &&
                   (out_item.item_valid || (out_item.item_time == 16'd0))))
    else $error("incoherent result fields");

endmodule

bind shortest_queue_multi_fifo_unit sqmf_chk u_sqmf_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

// File: dv/sqmf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqmf_checker: result predictor and scoreboard for the multi-FIFO unit
// Mirrors the queue bank from accepted transactions and configuration
// writes, then compares every posted result with the oldest expectation.
// ----------------------------------------------------------------------------
module sqmf_checker
  import sqmf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  in_item_t   in_item,
  input  logic       out_valid,
  input  out_item_t  out_item,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [3:0] cfg_data,
  output int         fail_count,
  output int         pending,
  output int         results_seen
);

  localparam int NUM_QUEUES = 8;
  localparam int SLOTS      = 16;
  localparam int REPORT_MAX = 10;

  logic [15:0] slot_mem [0:NUM_QUEUES*SLOTS-1];
  logic [3:0]  head_ptr [0:NUM_QUEUES-1];
  logic [4:0]  fill_lvl [0:NUM_QUEUES-1];
  logic [3:0]  in_use_reg;

  out_item_t result_q[$];
  int        mismatches = 0;
  int        seen       = 0;

  assign fail_count   = mismatches;
  assign results_seen = seen;

  // 0 acts as one queue, anything past the bank size saturates
  function automatic int active_count();
    if (in_use_reg == 4'd0) return 1;
    if (int'(in_use_reg) > NUM_QUEUES) return NUM_QUEUES;
    return int'(in_use_reg);
  endfunction

  task automatic dispatch_or_pop(input in_item_t it, output out_item_t res);
    int n;
    int best;
    int pos;
    int q;
    int sel;
    res = '0;
    n = active_count();
    if (it.kind == KIND_ARRIVE) begin
      best = 0;
      for (q = 1; q < n; q++) begin
        if (fill_lvl[q] < fill_lvl[best]) best = q;
      end
      res.queue_number = best[2:0];
      if (int'(fill_lvl[best]) < SLOTS) begin
        pos = int'(head_ptr[best]) + int'(fill_lvl[best]);
        if (pos >= SLOTS) pos -= SLOTS;
        slot_mem[best*SLOTS + pos] = it.exec_time;
        fill_lvl[best] = fill_lvl[best] + 5'd1;
        res.accepted = 1'b1;
      end
    end else begin
      sel = int'(it.queue_index);
      res.queue_number = it.queue_index;
      if (sel < n && fill_lvl[sel] != 5'd0) begin
        res.item_time = slot_mem[sel*SLOTS + int'(head_ptr[sel])];
        head_ptr[sel] = (head_ptr[sel] == 4'(SLOTS-1)) ? 4'd0 : head_ptr[sel] + 4'd1;
        fill_lvl[sel] = fill_lvl[sel] - 5'd1;
        res.item_valid = 1'b1;
      end
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t pred;
    int i;
    if (!rst_n) begin
      for (i = 0; i < NUM_QUEUES; i++) begin
        head_ptr[i] = '0;
        fill_lvl[i] = '0;
      end
      in_use_reg = 4'd1;
      result_q.delete();
      pending <= 0;
    end else begin
      // retire the posted result first; a new transaction may land on the same edge
      if (out_valid) begin
        seen++;
        if (result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: unexpected result acc=%0b vld=%0b q=%0d time=%h",
                     $time, out_item.accepted, out_item.item_valid,
                     out_item.queue_number, out_item.item_time);
        end else begin
          want = result_q[0];
          result_q.delete(0);
          if (out_item.accepted !== want.accepted ||
              out_item.item_valid !== want.item_valid ||
              out_item.queue_number !== want.queue_number ||
              out_item.item_time !== want.item_time) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $display("%0t: mismatch exp acc=%0b vld=%0b q=%0d time=%h",
                       $time, want.accepted, want.item_valid, want.queue_number,
                       want.item_time);
              $display("%0t:          got acc=%0b vld=%0b q=%0d time=%h",
                       $time, out_item.accepted, out_item.item_valid,
                       out_item.queue_number, out_item.item_time);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) in_use_reg = cfg_data;
      if (start && !busy) begin
        dispatch_or_pop(in_item, pred);
        result_q = {result_q, pred};
      end
      pending <= result_q.size();
    end
  end

endmodule

// File: dv/shortest_queue_multi_fifo_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shortest_queue_multi_fifo_unit_tb: stimulus and verdict for the FIFO bank
// Runs a directed pass over empty, unused and full queues, then random
// phases of arrivals and serves under several active-queue counts.
// ----------------------------------------------------------------------------
module shortest_queue_multi_fifo_unit_tb;
  import sqmf_pkg::*;

  localparam int ITEMS_PER_PHASE = 62;
  localparam int NUM_PHASES      = 8;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_item_t   in_item;
  logic       out_valid;
  out_item_t  out_item;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [3:0] cfg_data;

  int fail_count;
  int pending;
  int results_seen;

  int n_arrive   = 0;
  int n_serve    = 0;
  int n_settings = 0;

  // shadow of the programmed queue count, used only to aim serves
  logic [3:0] in_use_shadow = 4'd1;

  shortest_queue_multi_fifo_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // the checker sits beside the block and only watches its ports
  sqmf_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_item     (out_item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // hard stop in case a handshake never completes
  initial begin
    #2000000;
    $display("shortest_queue_multi_fifo_unit_tb NOT OK");
    $finish;
  end

  function automatic int eff_active(input logic [3:0] v);
    if (v == 4'd0) return 1;
    if (v > 4'd8) return 8;
    return int'(v);
  endfunction

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap(input bit no_idle);
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(8, 40);
  endfunction

  // Present one transaction and hold it until the edge that takes it.
  // Leave start high when no gap follows, so the next transaction rides
  // straight in without a low blip on start.
  task automatic send_txn(input in_item_t it, input int gap);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    if (it.kind == KIND_ARRIVE) n_arrive++;
    else n_serve++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop start and hold off until every expected result has been posted.
  // The first edge lets the checker account for the last transaction.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Program the queue count; only called with the block drained.
  task automatic write_in_use(input logic [3:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid     <= 1'b0;
    in_use_shadow = v;
    n_settings++;
  endtask

  function automatic in_item_t mk_item(input logic k, input logic [15:0] t,
                                       input logic [2:0] q);
    in_item_t it;
    it.kind        = k;
    it.exec_time   = t;
    it.queue_index = q;
    return it;
  endfunction

  // random transaction: arrival share set per phase, serves mostly aimed
  // at active queues, times biased toward the extremes now and then
  function automatic in_item_t rand_item(input int arr_pct);
    in_item_t it;
    int r;
    it.kind = ($urandom_range(0, 99) < arr_pct) ? KIND_ARRIVE : KIND_SERVE;
    r = $urandom_range(0, 9);
    if (r == 0) it.exec_time = 16'h0000;
    else if (r == 1) it.exec_time = 16'hFFFF;
    else it.exec_time = 16'($urandom);
    if ($urandom_range(0, 3) != 0)
      it.queue_index = 3'($urandom_range(0, eff_active(in_use_shadow) - 1));
    else
      it.queue_index = 3'($urandom_range(0, 7));
    return it;
  endfunction

  initial begin
    logic [3:0] settings [0:NUM_PHASES-1];
    int ph;
    int k;
    int arr_pct;
    bit no_idle;

    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_data  = 4'd0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b0 | 1'b1;

    // ---- directed pass, one active queue after reset ----
    // serve an empty queue, then one outside the active range
    send_txn(mk_item(KIND_SERVE, 16'hFFFF, 3'd0), pick_gap(1'b0));
    send_txn(mk_item(KIND_SERVE, 16'h0000, 3'd7), pick_gap(1'b0));
    // fill queue 0 with the time extremes at the front
    send_txn(mk_item(KIND_ARRIVE, 16'h0000, 3'd7), pick_gap(1'b0));
    send_txn(mk_item(KIND_ARRIVE, 16'hFFFF, 3'd0), pick_gap(1'b0));
    for (k = 0; k < 14; k++)
      send_txn(mk_item(KIND_ARRIVE, 16'($urandom), 3'($urandom)), pick_gap(1'b0));
    // queue 0 is full now: this arrival must be dropped
    send_txn(mk_item(KIND_ARRIVE, 16'h5A5A, 3'd0), pick_gap(1'b0));
    // pop the extremes back out, then hit another unused queue
    send_txn(mk_item(KIND_SERVE, 16'h0000, 3'd0), pick_gap(1'b0));
    send_txn(mk_item(KIND_SERVE, 16'h0000, 3'd0), pick_gap(1'b0));
    send_txn(mk_item(KIND_SERVE, 16'hFFFF, 3'd5), pick_gap(1'b0));
    drain();

    // ---- random phases: zero, saturating, full bank, single queue and
    // in-between counts, with shrinking leaving entries in idle queues ----
    settings[0] = 4'd0;
    settings[1] = 4'd15;
    settings[2] = 4'd8;
    settings[3] = 4'd1;
    settings[4] = 4'd3;
    settings[5] = 4'($urandom_range(0, 15));
    settings[6] = 4'd8;
    settings[7] = 4'($urandom_range(2, 7));

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      write_in_use(settings[ph]);
      arr_pct = $urandom_range(35, 80);
      no_idle = ($urandom_range(0, 3) == 0);
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        send_txn(rand_item(arr_pct), pick_gap(no_idle));
        // now and then hold the sender until the block has emptied out
        if ($urandom_range(0, 99) < 3) drain();
      end
      drain();
    end

    // ---- wind down: everything should be retired by now ----
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d arrivals and %0d serves over %0d queue-count settings",
             n_arrive, n_serve, n_settings);
    $display("%0d results checked, %0d failures", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("shortest_queue_multi_fifo_unit_tb OK");
    end else begin
      $display("shortest_queue_multi_fifo_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
